### rtl/core/ett_pkg.sv
// ----------------------------------------------------------------------------
// ett_pkg: shared types and constants of the encoder turn tracker
// Opcodes, register indexes, reset values and the structs that travel
// between the configuration block, the tracker and the top level.
// ----------------------------------------------------------------------------
package ett_pkg;

  localparam int ANGLE_W    = 13;
  localparam int SPEED_W    = 16;
  localparam int TORQUE_W   = 16;
  localparam int COUNT_W    = 32;
  localparam int STIME_W    = 16;
  localparam int THR_W      = 13;
  localparam int TLIM_W     = 15;
  localparam int TIME_LIM_W = 16;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_FEEDBACK = 2'd0,
    OP_TICK     = 2'd1,
    OP_LOAD     = 2'd2
  } ett_op_t;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TORQUE_LIMIT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_TIME_LIMIT   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STALL_STEP         = 4'd3;

  localparam logic [THR_W-1:0]      RST_WRAP_THRESHOLD     = 13'd4000;
  localparam logic [TLIM_W-1:0]     RST_STALL_TORQUE_LIMIT = 15'd7000;
  localparam logic [TIME_LIM_W-1:0] RST_STALL_TIME_LIMIT   = 16'd500;
  localparam logic [STEP_W-1:0]     RST_STALL_STEP         = 8'd2;

  typedef struct packed {
    logic [THR_W-1:0]      wrap_threshold;
    logic [TLIM_W-1:0]     stall_torque_limit;
    logic [TIME_LIM_W-1:0] stall_time_limit;
    logic [STEP_W-1:0]     stall_step;
  } ett_cfg_t;

  typedef struct packed {
    logic [1:0]                  opcode;
    logic [ANGLE_W-1:0]          rotor_angle;
    logic signed [SPEED_W-1:0]   rotor_speed;
    logic signed [TORQUE_W-1:0]  rotor_torque;
    logic signed [COUNT_W-1:0]   start_count;
  } ett_item_t;

  typedef struct packed {
    logic signed [COUNT_W-1:0] total_count;
    logic                      stall_event;
    logic [STIME_W-1:0]        stall_time;
  } ett_result_t;

endpackage

### rtl/core/ett_in_if.sv
// ----------------------------------------------------------------------------
// ett_in_if: input item channel
// Valid/ready channel carrying one encoder feedback, tick or load item.
// ----------------------------------------------------------------------------
interface ett_in_if import ett_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 opcode;
  logic [ANGLE_W-1:0]         rotor_angle;
  logic signed [SPEED_W-1:0]  rotor_speed;
  logic signed [TORQUE_W-1:0] rotor_torque;
  logic signed [COUNT_W-1:0]  start_count;

  modport source (
    output valid, opcode, rotor_angle, rotor_speed, rotor_torque, start_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, rotor_angle, rotor_speed, rotor_torque, start_count,
    output ready
  );
endinterface

### rtl/core/ett_out_if.sv
// ----------------------------------------------------------------------------
// ett_out_if: result channel
// Valid/ready channel carrying the multi-turn total and the stall status.
// ----------------------------------------------------------------------------
interface ett_out_if import ett_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COUNT_W-1:0] total_count;
  logic                      stall_event;
  logic [STIME_W-1:0]        stall_time;

  modport source (
    output valid, total_count, stall_event, stall_time,
    input  ready
  );
  modport sink (
    input  valid, total_count, stall_event, stall_time,
    output ready
  );
endinterface

### rtl/core/ett_cfg_if.sv
// ----------------------------------------------------------------------------
// ett_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface ett_cfg_if import ett_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/encoder_turn_tracker_stall_detect.sv
// ----------------------------------------------------------------------------
// encoder_turn_tracker_stall_detect: multi-turn encoder unwrap, stall detect
// A transaction passes through the input register, then through the
// tracker into the output register. One item is taken per cycle while
// the result channel is not stalling the output register.
// Synchronous active-low reset clears the tracker state and the valid flags
// and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module encoder_turn_tracker_stall_detect import ett_pkg::*; #(
  parameter int ENCODER_SPAN = 8191,
  parameter int TOTAL_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ett_in_if.sink      in_ch,
  ett_out_if.source   out_ch,
  ett_cfg_if.sink     cfg_ch
);

  // Configuration writes are always taken; the register file drops writes
  // to indexes it does not know.
  ett_cfg_t cfg;

  assign cfg_ch.ready = 1'b1;

  ett_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // The pipeline moves whenever the output register is empty or being
  // drained. The input register can therefore take a new transaction while
  // a finished result still sits in the output register, as long as the
  // input stage itself is free or about to move.
  logic        s1_valid_r, s1_valid_nxt;
  ett_item_t   s1_item_r;
  logic        out_valid_r, out_valid_nxt;
  ett_result_t out_data_r;
  ett_result_t result;
  logic        advance;
  logic        fire;
  logic        in_take;

  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid flags guard them.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.opcode       <= in_ch.opcode;
      s1_item_r.rotor_angle  <= in_ch.rotor_angle;
      s1_item_r.rotor_speed  <= in_ch.rotor_speed;
      s1_item_r.rotor_torque <= in_ch.rotor_torque;
      s1_item_r.start_count  <= in_ch.start_count;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  // The tracker reads its state, applies the item held in the input
  // register and commits the new state on the same edge that loads the
  // output register, so the next item sees the updated state.
  ett_tracker #(
    .ENCODER_SPAN (ENCODER_SPAN),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) u_tracker (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.total_count = out_data_r.total_count;
  assign out_ch.stall_event = out_data_r.stall_event;
  assign out_ch.stall_time  = out_data_r.stall_time;

endmodule

### rtl/core/ett_cfg_regs.sv
// ----------------------------------------------------------------------------
// ett_cfg_regs: configuration registers
// Holds the wrap threshold and the stall limits; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module ett_cfg_regs import ett_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output ett_cfg_t              cfg
);

  ett_cfg_t cfg_r;
  ett_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_WRAP_THRESHOLD:     cfg_nxt.wrap_threshold     = wr_data[THR_W-1:0];
        REG_STALL_TORQUE_LIMIT: cfg_nxt.stall_torque_limit = wr_data[TLIM_W-1:0];
        REG_STALL_TIME_LIMIT:   cfg_nxt.stall_time_limit   = wr_data[TIME_LIM_W-1:0];
        REG_STALL_STEP:         cfg_nxt.stall_step         = wr_data[STEP_W-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wrap_threshold     <= RST_WRAP_THRESHOLD;
      cfg_r.stall_torque_limit <= RST_STALL_TORQUE_LIMIT;
      cfg_r.stall_time_limit   <= RST_STALL_TIME_LIMIT;
      cfg_r.stall_step         <= RST_STALL_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/ett_tracker.sv
// ----------------------------------------------------------------------------
// ett_tracker: encoder state, wrap correction and stall timer
// Applies one item to the tracker state when fire is high and presents the
// result of that item combinationally.
// ----------------------------------------------------------------------------
module ett_tracker import ett_pkg::*; #(
  parameter int ENCODER_SPAN = 8191,
  parameter int TOTAL_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  ett_item_t   item,
  input  ett_cfg_t    cfg,
  output ett_result_t result
);

  // The angle delta plus or minus the span must fit, and the raw 13-bit
  // difference needs 15 bits with margin for the threshold negation.
  localparam int SPAN_W = $clog2(ENCODER_SPAN + 1);
  localparam int DW     = (SPAN_W + 2 > 15) ? SPAN_W + 2 : 15;
  localparam int SW     = (TOTAL_WIDTH > DW) ? TOTAL_WIDTH : DW;
  localparam int XW     = (TOTAL_WIDTH > COUNT_W) ? TOTAL_WIDTH : COUNT_W;
  localparam logic signed [DW-1:0] SPAN_S = DW'(ENCODER_SPAN);

  logic [ANGLE_W-1:0]             cur_angle_r, cur_angle_nxt;
  logic signed [SPEED_W-1:0]      cur_speed_r, cur_speed_nxt;
  logic signed [TORQUE_W-1:0]     cur_torque_r, cur_torque_nxt;
  logic [ANGLE_W-1:0]             prev_angle_r, prev_angle_nxt;
  logic signed [TOTAL_WIDTH-1:0]  turn_total_r, turn_total_nxt;
  logic [STIME_W-1:0]             stall_counter_r, stall_counter_nxt;

  logic signed [DW-1:0]       cur_s, prev_s, thr_s, diff, delta;
  logic signed [SW-1:0]       total_sum;
  logic signed [TORQUE_W:0]   torque_x;
  logic [TORQUE_W:0]          torque_abs;
  logic                       stalled;
  logic [STIME_W-1:0]         count_inc;
  logic                       event_flag;
  logic signed [XW-1:0]       total_ext;

  always_comb begin
    cur_s  = DW'($signed({1'b0, cur_angle_r}));
    prev_s = DW'($signed({1'b0, prev_angle_r}));
    thr_s  = DW'($signed({1'b0, cfg.wrap_threshold}));
    diff   = cur_s - prev_s;
    if (diff < -thr_s) begin
      delta = diff + SPAN_S;
    end else if (diff > thr_s) begin
      delta = diff - SPAN_S;
    end else begin
      delta = diff;
    end
    total_sum = SW'(turn_total_r) + SW'(delta);

    torque_x   = (TORQUE_W + 1)'(cur_torque_r);
    torque_abs = torque_x[TORQUE_W] ? unsigned'(-torque_x) : unsigned'(torque_x);
    stalled    = (cur_speed_r == '0) &&
                 (torque_abs > (TORQUE_W + 1)'(cfg.stall_torque_limit));
    count_inc  = stall_counter_r + STIME_W'(cfg.stall_step);
  end

  always_comb begin
    cur_angle_nxt     = cur_angle_r;
    cur_speed_nxt     = cur_speed_r;
    cur_torque_nxt    = cur_torque_r;
    prev_angle_nxt    = prev_angle_r;
    turn_total_nxt    = turn_total_r;
    stall_counter_nxt = stall_counter_r;
    event_flag        = 1'b0;
    case (item.opcode)
      OP_FEEDBACK: begin
        cur_angle_nxt  = item.rotor_angle;
        cur_speed_nxt  = item.rotor_speed;
        cur_torque_nxt = item.rotor_torque;
      end
      OP_TICK: begin
        turn_total_nxt = total_sum[TOTAL_WIDTH-1:0];
        prev_angle_nxt = cur_angle_r;
        if (stalled) begin
          stall_counter_nxt = count_inc;
        end else begin
          stall_counter_nxt = '0;
        end
        if (stall_counter_nxt > cfg.stall_time_limit) begin
          event_flag        = 1'b1;
          stall_counter_nxt = '0;
        end
      end
      OP_LOAD: begin
        turn_total_nxt = TOTAL_WIDTH'(item.start_count);
        prev_angle_nxt = cur_angle_r;
      end
      default: begin
        // The spare opcode leaves the state alone and reports it.
        cur_angle_nxt = cur_angle_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_angle_r     <= '0;
      cur_speed_r     <= '0;
      cur_torque_r    <= '0;
      prev_angle_r    <= '0;
      turn_total_r    <= '0;
      stall_counter_r <= '0;
    end else if (fire) begin
      cur_angle_r     <= cur_angle_nxt;
      cur_speed_r     <= cur_speed_nxt;
      cur_torque_r    <= cur_torque_nxt;
      prev_angle_r    <= prev_angle_nxt;
      turn_total_r    <= turn_total_nxt;
      stall_counter_r <= stall_counter_nxt;
    end
  end

  always_comb begin
    total_ext          = XW'(turn_total_nxt);
    result.total_count = total_ext[COUNT_W-1:0];
    result.stall_event = event_flag;
    result.stall_time  = stall_counter_nxt;
  end

endmodule

### dv/encoder_turn_tracker_stall_detect_test.sv
// ----------------------------------------------------------------------------
// encoder_turn_tracker_stall_detect_test: self-checking bench for the tracker
// Feeds feedback, tick and load transactions into the encoder turn tracker.
// A local model unwraps the angle, keeps the multi-turn total and runs the
// stall timer. Every result transaction is compared field by field against
// that model. Directed corner cases run first, then register settings that
// include the extremes, then random settings. Both channels idle and stall
// at random, and a watchdog catches a hung handshake.
// ----------------------------------------------------------------------------
module encoder_turn_tracker_stall_detect_test import ett_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int ENCODER_SPAN   = 8191;
  localparam int TOTAL_WIDTH    = COUNT_W;
  // A result passes the input and output registers of the block. The pauses
  // below leave margin on top of that pipeline.
  localparam int DRAIN_CYCLES   = 4;
  localparam int END_CYCLES     = 10;
  // Cycles without any transaction on any channel before the run is declared
  // hung. Random gaps at the highest idle rate stay far below this.
  localparam int WATCHDOG_LIMIT = 2000;

  // The package enum has no name for the spare opcode. The block must treat
  // it as a no-op that still reports the current state.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Highest register index. No register sits here, so a write must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hF;

  // Idle percentages for the four traffic modes. The modes are no idling,
  // sender idle, receiver stalling, and both.
  localparam int SEND_GAP_PCT [4] = '{0, 65, 0, 21};
  localparam int RECV_GAP_PCT [4] = '{0, 0, 65, 21};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  ett_in_if  in_ch ();
  ett_out_if out_ch ();
  ett_cfg_if cfg_ch ();

  encoder_turn_tracker_stall_detect #(
    .ENCODER_SPAN (ENCODER_SPAN),
    .TOTAL_WIDTH  (TOTAL_WIDTH)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local copy of the registers. It is updated when a configuration write
  // is accepted. Writes only happen while the tracker is idle, so this copy
  // always matches what the block uses for the next input transaction.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]      cfg_wrap_thr   = RST_WRAP_THRESHOLD;
  logic [TLIM_W-1:0]     cfg_torque_lim = RST_STALL_TORQUE_LIMIT;
  logic [TIME_LIM_W-1:0] cfg_stall_lim  = RST_STALL_TIME_LIMIT;
  logic [STEP_W-1:0]     cfg_step       = RST_STALL_STEP;

  // Tracker state of the model, which starts at zero just like the block after reset.
  logic [ANGLE_W-1:0]         fb_angle    = '0;
  logic signed [SPEED_W-1:0]  fb_speed    = '0;
  logic signed [TORQUE_W-1:0] fb_torque   = '0;
  logic [ANGLE_W-1:0]         last_angle  = '0;
  logic signed [COUNT_W-1:0]  turn_total  = '0;
  logic [STIME_W-1:0]         stall_timer = '0;

  ett_item_t   encoder_items [$];   // transactions waiting to be driven
  ett_result_t pending_status [$];  // predicted results, oldest first
  int          items_queued   = 0;
  int          items_taken    = 0;
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles    = 0;
  int          gen_angle      = 0;  // angle walk used to build random feedback

  // ---------------------------------------------------------------------------
  // Model of one accepted transaction. It updates the local state and returns
  // the result that the block has to report for it.
  // ---------------------------------------------------------------------------
  function automatic ett_result_t advance_tracker(input ett_item_t it);
    ett_result_t res;
    int          delta;
    int          thr;
    int          abs_torque;
    res.stall_event = 1'b0;
    case (it.opcode)
      OP_FEEDBACK: begin
        fb_angle  = it.rotor_angle;
        fb_speed  = it.rotor_speed;
        fb_torque = it.rotor_torque;
      end
      OP_TICK: begin
        // A jump wider than the threshold in either direction means the
        // encoder crossed its zero. So fold the jump back by one span.
        delta = int'(fb_angle) - int'(last_angle);
        thr   = int'(cfg_wrap_thr);
        if (delta < -thr) begin
          delta = delta + ENCODER_SPAN;
        end else if (delta > thr) begin
          delta = delta - ENCODER_SPAN;
        end
        turn_total = turn_total + delta;
        last_angle = fb_angle;
        // The most negative torque has magnitude 32768. That is past every
        // possible limit, so it must still count as stalled.
        abs_torque = (fb_torque < 0) ? -int'(fb_torque) : int'(fb_torque);
        if (fb_speed == 0 && abs_torque > int'(cfg_torque_lim)) begin
          stall_timer = stall_timer + cfg_step;
        end else begin
          stall_timer = '0;
        end
        if (stall_timer > cfg_stall_lim) begin
          res.stall_event = 1'b1;
          stall_timer     = '0;
        end
      end
      OP_LOAD: begin
        turn_total = it.start_count;
        last_angle = fb_angle;
      end
      default: ;
    endcase
    res.total_count = turn_total;
    res.stall_time  = stall_timer;
    return res;
  endfunction

  // A transaction with every field random. Callers then overwrite the fields
  // that matter for the opcode they want.
  function automatic ett_item_t random_item();
    ett_item_t it;
    int        raw;
    raw             = $urandom_range(3);
    it.opcode       = raw[1:0];
    raw             = $urandom;
    it.rotor_angle  = raw[ANGLE_W-1:0];
    raw             = $urandom;
    it.rotor_speed  = raw[SPEED_W-1:0];
    raw             = $urandom;
    it.rotor_torque = raw[TORQUE_W-1:0];
    it.start_count  = $urandom;
    return it;
  endfunction

  task automatic queue_item(input ett_item_t it);
    encoder_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_item(input logic [1:0] op, input int angle, input int speed,
                           input int torque, input int count);
    ett_item_t it;
    it.opcode       = op;
    it.rotor_angle  = angle[ANGLE_W-1:0];
    it.rotor_speed  = speed[SPEED_W-1:0];
    it.rotor_torque = torque[TORQUE_W-1:0];
    it.start_count  = count;
    queue_item(it);
  endtask

  // Random traffic that follows how the tracker is really used. Most feedback
  // transactions move the angle a little from the previous one and are
  // followed by a short run of ticks. Speed is often zero and torque often
  // sits at the stall limit or at full scale, so the stall timer gets to
  // build up. Loads, ticks without fresh feedback and the spare opcode are
  // mixed in as noise. Spare opcode transactions do not count toward the total.
  task automatic push_random_items(input int count, input int max_ticks);
    ett_item_t it;
    int        made;
    int        level;
    made = 0;
    while (made < count) begin
      it = random_item();
      case ($urandom_range(19))
        0: it.opcode = OP_LOAD;
        1: it.opcode = OP_UNUSED;
        2: it.opcode = OP_TICK;
        default: begin
          it.opcode = OP_FEEDBACK;
          if ($urandom_range(9) < 7) begin
            gen_angle = (gen_angle + 8192 + int'($urandom_range(1200)) - 600) % 8192;
          end else begin
            gen_angle = $urandom_range(8191);
          end
          it.rotor_angle = gen_angle[ANGLE_W-1:0];
          if ($urandom_range(9) < 6) begin
            it.rotor_speed = '0;
          end
          level = int'(cfg_torque_lim) + int'($urandom_range(1));
          case ($urandom_range(4))
            0: ;
            1: it.rotor_torque = 16'sh8000;
            2: it.rotor_torque = 16'sh7FFF;
            3: it.rotor_torque = level[TORQUE_W-1:0];
            default: begin
              level           = -level;
              it.rotor_torque = level[TORQUE_W-1:0];
            end
          endcase
        end
      endcase
      queue_item(it);
      if (it.opcode != OP_UNUSED) begin
        made++;
      end
      if (it.opcode == OP_FEEDBACK) begin
        repeat ($urandom_range(max_ticks, 1)) begin
          it        = random_item();
          it.opcode = OP_TICK;
          queue_item(it);
          made++;
        end
      end
    end
  endtask

  // One register write. The local copy is masked to the register width in
  // the same way as the block masks the write data.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_WRAP_THRESHOLD:     cfg_wrap_thr   = value[THR_W-1:0];
      REG_STALL_TORQUE_LIMIT: cfg_torque_lim = value[TLIM_W-1:0];
      REG_STALL_TIME_LIMIT:   cfg_stall_lim  = value[TIME_LIM_W-1:0];
      REG_STALL_STEP:         cfg_step       = value[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int wrap_thr, input int torque_lim,
                            input int stall_lim, input int step);
    write_reg(REG_WRAP_THRESHOLD, wrap_thr);
    write_reg(REG_STALL_TORQUE_LIMIT, torque_lim);
    write_reg(REG_STALL_TIME_LIMIT, stall_lim);
    write_reg(REG_STALL_STEP, step);
  endtask

  task automatic set_traffic(input int mode);
    send_idle_pct  = SEND_GAP_PCT[mode];
    recv_stall_pct = RECV_GAP_PCT[mode];
  endtask

  // Waits until every queued transaction has been taken and every predicted
  // result has come back. Then it lets the pipeline settle before registers
  // may change. The two counters move together with the queue of predicted
  // results in the driver, so the check cannot race a transaction that is
  // being accepted at the same edge.
  task automatic drain_results();
    do @(posedge clk); while (items_taken != items_queued || pending_status.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: it presents queued transactions on the input channel and may
  // insert random idle cycles. A transaction is predicted at the edge where
  // it is accepted, using the values that were on the channel at that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    ett_item_t taken;
    ett_item_t next;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken = '{in_ch.opcode, in_ch.rotor_angle, in_ch.rotor_speed,
                  in_ch.rotor_torque, in_ch.start_count};
        pending_status.push_back(advance_tracker(taken));
        items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (encoder_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next = encoder_items.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.opcode       <= next.opcode;
          in_ch.rotor_angle  <= next.rotor_angle;
          in_ch.rotor_speed  <= next.rotor_speed;
          in_ch.rotor_torque <= next.rotor_torque;
          in_ch.start_count  <= next.start_count;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: it applies random back-pressure on the result channel and
  // checks each accepted result against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ett_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: result with nothing predicted, expected none, actual total %0d",
                 $time, out_ch.total_count);
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        if (out_ch.total_count !== want.total_count) begin
          $display("%0t: total_count expected %0d actual %0d",
                   $time, want.total_count, out_ch.total_count);
          mismatches++;
        end
        if (out_ch.stall_event !== want.stall_event) begin
          $display("%0t: stall_event expected %0b actual %0b",
                   $time, want.stall_event, out_ch.stall_event);
          mismatches++;
        end
        if (out_ch.stall_time !== want.stall_time) begin
          $display("%0t: stall_time expected %0d actual %0d",
                   $time, want.stall_time, out_ch.stall_time);
          mismatches++;
        end
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int phase;
    int step;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_FEEDBACK;
    in_ch.rotor_angle  = '0;
    in_ch.rotor_speed  = '0;
    in_ch.rotor_torque = '0;
    in_ch.start_count  = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_WRAP_THRESHOLD;
    cfg_ch.data        = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the reset register values and no idling. The
    // threshold is 4000 and the torque limit is 7000.
    set_traffic(0);
    push_item(OP_FEEDBACK, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // A jump to the top of the range is a wrap of exactly one span, so the
    // tick adds nothing.
    push_item(OP_FEEDBACK, 8191, 32767, -32768, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // This is a wrap in the other direction.
    push_item(OP_FEEDBACK, 100, -32768, 32767, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // A change that equals the threshold is not a wrap in either sign.
    push_item(OP_FEEDBACK, 4100, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_FEEDBACK, 100, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // One count past the threshold is a wrap.
    push_item(OP_FEEDBACK, 4101, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // The total wraps past the largest and the smallest 32-bit value.
    push_item(OP_LOAD, 0, 0, 0, 32'h7FFF_FFFF);
    push_item(OP_FEEDBACK, 4200, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_LOAD, 0, 0, 0, 32'h8000_0000);
    push_item(OP_FEEDBACK, 4100, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    // The spare opcode, with random content.
    push_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom);
    // The stall timer counts up at full negative torque. It is cleared at a
    // torque equal to the limit and cleared again once speed is nonzero.
    push_item(OP_FEEDBACK, 4100, 0, -32768, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_FEEDBACK, 4100, 0, 7000, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_FEEDBACK, 4100, 0, -7001, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_FEEDBACK, 4100, -1, 32767, 0);
    push_item(OP_TICK, 0, 0, 0, 0);
    push_item(OP_LOAD, 0, 0, 0, 0);
    drain_results();

    // All registers at their lowest values, apart from the step. Any change
    // counts as a wrap and every stalled tick raises an event. A write to the
    // unmapped index must leave the settings untouched.
    set_config(0, 0, 0, 1);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    set_traffic(1);
    push_random_items(120, 4);
    drain_results();

    // All data bits are set, so every register gets its highest value after
    // masking. Only the most negative torque still exceeds the limit. A long
    // stalled run then drives the 16-bit timer past its top, and it wraps
    // without raising an event.
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_traffic(2);
    push_item(OP_FEEDBACK, 0, 0, -32768, 0);
    repeat (300) push_item(OP_TICK, 0, 0, 0, 0);
    push_random_items(100, 6);
    drain_results();

    // A zero step holds the timer at whatever value it has reached.
    set_config($urandom_range(8191), $urandom_range(32767), 40, 0);
    set_traffic(3);
    push_random_items(120, 6);
    drain_results();

    // Random settings. The time limit is kept within 20 steps, so that stall
    // events show up often.
    for (phase = 0; phase < 5; phase++) begin
      step = $urandom_range(255, 1);
      set_config($urandom_range(8191), $urandom_range(32767), $urandom_range(20 * step), step);
      set_traffic(phase % 4);
      push_random_items(120, 8);
      drain_results();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
